>>> design/lzw_compressor_word_packer_assert.svh
// Assertion macros shared by the compressor top level.
`ifndef LZW_COMPRESSOR_WORD_PACKER_ASSERT_SVH
`define LZW_COMPRESSOR_WORD_PACKER_ASSERT_SVH
`ifndef SYNTH
`define LZWP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzwp same-cycle check failed");
`define LZWP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzwp next-cycle check failed");
`else
`define LZWP_ASSERT_IMP(lbl, ante, cons)
`define LZWP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/lzwp_pkg.sv
// Shared constants and controller/datapath signal groups for the LZW word packer.
package lzwp_pkg;
  localparam int MAX_CODE_BITS = 12;
  localparam int MIN_CODE_BITS = 9;
  localparam int TABLE_DEPTH   = 1 << MAX_CODE_BITS;
  localparam int WORD_BITS     = 32;

  localparam logic [MAX_CODE_BITS-1:0] END_CODE  = MAX_CODE_BITS'(256);
  localparam logic [MAX_CODE_BITS:0]   FIRST_FREE = (MAX_CODE_BITS+1)'(257);
  localparam logic [3:0]               CODE_BITS_RST = 4'd12;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef logic [MAX_CODE_BITS-1:0] code_t;

  typedef struct packed {
    logic load;
    logic start_str;
    logic look;
    logic cmp_step;
    logic hit;
    logic pack;
    logic pack_end;
    logic add_entry;
    logic add_clear;
    logic restart;
    logic flush;
  } lzwp_cmd_t;

  typedef struct packed {
    logic started;
    logic child_zero;
    logic match;
    logic sib_zero;
    logic tbl_ok;
    logic slot_free;
  } lzwp_status_t;
endpackage

>>> design/lzwp_stream_if.sv
// Valid/ready stream interfaces for the input bytes and the packed words.
interface lzwp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface lzwp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  logic        last;
  modport source (output valid, output packed_word, output last, input ready);
  modport sink   (input valid, input packed_word, input last, output ready);
endinterface

>>> design/lzwp_ctrl.sv
// Sequencing state machine for lookup, entry insertion, packing and finish.
module lzwp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_command,
  output logic                  in_ready,
  input  lzwp_pkg::lzwp_status_t st,
  output lzwp_pkg::lzwp_cmd_t   cmd
);
  import lzwp_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOOK     = 3'd1;
  localparam logic [2:0] S_CMP      = 3'd2;
  localparam logic [2:0] S_ADD      = 3'd3;
  localparam logic [2:0] S_ADD2     = 3'd4;
  localparam logic [2:0] S_FIN_CUR  = 3'd5;
  localparam logic [2:0] S_FIN_END  = 3'd6;
  localparam logic [2:0] S_FIN_LAST = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_command == CMD_FINISH) begin
            state_nxt = S_FIN_CUR;
          end else if (!st.started) begin
            cmd.start_str = 1'b1;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = st.child_zero ? S_ADD : S_CMP;
      end
      S_CMP: begin
        if (st.match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_IDLE;
        end else if (st.sib_zero) begin
          state_nxt = S_ADD;
        end else begin
          cmd.cmp_step = 1'b1;
        end
      end
      S_ADD: begin
        if (st.slot_free) begin
          cmd.pack = 1'b1;
          if (st.tbl_ok) begin
            cmd.add_entry = 1'b1;
            state_nxt     = S_ADD2;
          end else begin
            cmd.restart = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_ADD2: begin
        cmd.add_clear = 1'b1;
        cmd.restart   = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FIN_CUR: begin
        if (!st.started) begin
          state_nxt = S_FIN_END;
        end else if (st.slot_free) begin
          cmd.pack  = 1'b1;
          state_nxt = S_FIN_END;
        end
      end
      S_FIN_END: begin
        if (st.slot_free) begin
          cmd.pack     = 1'b1;
          cmd.pack_end = 1'b1;
          state_nxt    = S_FIN_LAST;
        end
      end
      S_FIN_LAST: begin
        if (st.slot_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> design/lzwp_dp.sv
// Dictionary memories, string registers, bit packer and output register.
module lzwp_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_wdata,
  input  logic [7:0]             in_byte,
  input  lzwp_pkg::lzwp_cmd_t    cmd,
  output lzwp_pkg::lzwp_status_t st,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [31:0]            out_word,
  output logic                   out_last
);
  import lzwp_pkg::*;

  // first child per code, and per entry its byte and next sibling
  code_t      fc_mem   [TABLE_DEPTH];
  code_t      sib_mem  [TABLE_DEPTH];
  logic [7:0] byte_mem [TABLE_DEPTH];

  logic [255:0]         root_v_r;
  logic [3:0]           code_bits_r;
  code_t                cur_r;
  logic [7:0]           byte_r;
  logic                 started_r;
  logic [MAX_CODE_BITS:0] next_r;
  code_t                fc_r, ptr_r;
  code_t                fc_rd_r, sib_rd_r;
  logic [7:0]           byte_rd_r;
  logic [31:0]          buf_r;
  logic [5:0]           free_r;
  logic                 out_valid_r, out_last_r;
  logic [31:0]          out_word_r;

  logic [3:0]           w;
  code_t                mask, code_in, v, child, node_addr;
  logic                 root_miss, slot_free, fits, emit;
  logic [4:0]           pos;
  logic [43:0]          sh;
  logic [31:0]          word_full, buf_nxt;
  logic [5:0]           free_nxt, w6;

  always_comb begin
    if (code_bits_r < 4'(MIN_CODE_BITS)) w = 4'(MIN_CODE_BITS);
    else if (code_bits_r > 4'(MAX_CODE_BITS)) w = 4'(MAX_CODE_BITS);
    else w = code_bits_r;
  end

  assign mask      = MAX_CODE_BITS'(({1'b0, {MAX_CODE_BITS{1'b1}}}) >> (4'(MAX_CODE_BITS) - w));
  assign root_miss = (cur_r[MAX_CODE_BITS-1:8] == '0) && !root_v_r[cur_r[7:0]];
  assign child     = root_miss ? '0 : fc_rd_r;
  assign node_addr = cmd.look ? child : sib_rd_r;
  assign slot_free = !out_valid_r || out_ready;

  assign st.started    = started_r;
  assign st.child_zero = (child == '0);
  assign st.match      = (byte_rd_r == byte_r);
  assign st.sib_zero   = (sib_rd_r == '0);
  assign st.tbl_ok     = (next_r < ((MAX_CODE_BITS+1)'(1) << w))
                         && (next_r < (MAX_CODE_BITS+1)'(TABLE_DEPTH));
  assign st.slot_free  = slot_free;

  // packer
  assign code_in   = cmd.pack_end ? END_CODE : cur_r;
  assign v         = code_in & mask;
  assign pos       = 5'(6'd32 - free_r);
  assign sh        = {32'd0, v} << pos;
  assign w6        = {2'b00, w};
  assign fits      = w6 < free_r;
  assign word_full = buf_r | sh[31:0];
  assign emit      = (cmd.pack && !fits) || cmd.flush;

  always_comb begin
    buf_nxt  = buf_r;
    free_nxt = free_r;
    if (cmd.flush) begin
      buf_nxt  = '0;
      free_nxt = 6'd32;
    end else if (cmd.pack) begin
      if (fits) begin
        buf_nxt  = word_full;
        free_nxt = free_r - w6;
      end else if (w6 > free_r) begin
        buf_nxt  = 32'(v >> free_r);
        free_nxt = 6'd32 - (w6 - free_r);
      end else begin
        buf_nxt  = '0;
        free_nxt = 6'd32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_v_r    <= '0;
      code_bits_r <= CODE_BITS_RST;
      cur_r       <= '0;
      started_r   <= 1'b0;
      next_r      <= FIRST_FREE;
      buf_r       <= '0;
      free_r      <= 6'd32;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) code_bits_r <= cfg_wdata;
      if (cmd.start_str) begin
        cur_r     <= code_t'(in_byte);
        started_r <= 1'b1;
      end
      if (cmd.hit) cur_r <= ptr_r;
      if (cmd.restart) cur_r <= code_t'(byte_r);
      if (cmd.flush) started_r <= 1'b0;
      if (cmd.add_entry && cur_r[MAX_CODE_BITS-1:8] == '0) root_v_r[cur_r[7:0]] <= 1'b1;
      if (cmd.add_clear) next_r <= next_r + 1'b1;
      buf_r  <= buf_nxt;
      free_r <= free_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) byte_r <= in_byte;
    if (cmd.look) fc_r <= child;
    if (cmd.look || cmd.cmp_step) ptr_r <= node_addr;
    if (emit) begin
      out_word_r <= cmd.flush ? buf_r : word_full;
      out_last_r <= cmd.flush;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    fc_rd_r <= fc_mem[cur_r];
    if (cmd.add_entry) fc_mem[cur_r] <= next_r[MAX_CODE_BITS-1:0];
    else if (cmd.add_clear) fc_mem[next_r[MAX_CODE_BITS-1:0]] <= '0;
  end

  always_ff @(posedge clk) begin
    sib_rd_r  <= sib_mem[node_addr];
    byte_rd_r <= byte_mem[node_addr];
    if (cmd.add_entry) begin
      sib_mem[next_r[MAX_CODE_BITS-1:0]]  <= fc_r;
      byte_mem[next_r[MAX_CODE_BITS-1:0]] <= byte_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;
endmodule

>>> design/lzw_compressor_word_packer.sv
// LZW compressor top level: fixed-width codes packed least significant bit first into 32-bit
// words. Each dictionary entry keeps its byte and a link to its next sibling, and each code a
// link to its first child, so a lookup walks the children of the current string one per cycle
// through registered memory reads. A byte that starts a string needs no lookup; on a match
// the string extends to the matched code; on a miss the current code is packed, an entry is
// added while the table has room, and a new string starts from the byte. Finish packs the
// current code and end code, then flushes, each waiting on a free output slot. The output
// register lets lookups go on while a word waits; packing holds until the register is free.
// Reset clears only 256 root valid bits, so there is no clearing pass.
// Write code_bits only while idle; values below 9 act as 9, above 12 as 12.
module lzw_compressor_word_packer (
  input  logic       clk,
  input  logic       rst_n,
  lzwp_in_if.sink    in_ch,
  lzwp_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);
  import lzwp_pkg::*;

`include "lzw_compressor_word_packer_assert.svh"

  lzwp_cmd_t    cmd;
  lzwp_status_t st;

  // sequence each transaction through lookup, insertion and packing
  lzwp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .st         (st),
    .cmd        (cmd)
  );

  // hold dictionary, string state, bit buffer and output word
  lzwp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_ch.data_byte),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_word  (out_ch.packed_word),
    .out_last  (out_ch.last)
  );

  // never overwrite a word still waiting at the output
  `LZWP_ASSERT_IMP(a_pack_slot, cmd.pack || cmd.flush, st.slot_free)
  // add entries only while the table has room
  `LZWP_ASSERT_IMP(a_add_room, cmd.add_entry, st.tbl_ok)
  // the final word appears marked last straight after the flush
  `LZWP_ASSERT_NXT(a_flush_last, cmd.flush, out_ch.valid && out_ch.last)
  // a finish transaction keeps the block busy the following cycle
  `LZWP_ASSERT_NXT(a_fin_busy, in_ch.valid && in_ch.ready && in_ch.command == CMD_FINISH,
                   !in_ch.ready)
endmodule
